@@ hdl/sorted_insertion_list_core_macros.svh @@
// assertion macros shared by the sorted insertion list checker
`ifndef SORTED_INSERTION_LIST_CORE_MACROS_SVH
`define SORTED_INSERTION_LIST_CORE_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge outside reset
`define SIL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on the rising clock edge outside reset
`define SIL_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/sil_pkg.sv @@
// shared codes and controller/datapath interface types for the sorted insertion list
package sil_pkg;

    // operation codes of an input word
    localparam logic [1:0] OP_INSERT    = 2'd0;
    localparam logic [1:0] OP_DUMP_ASC  = 2'd1;
    localparam logic [1:0] OP_DUMP_DESC = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_INSERTED = 2'd0;
    localparam logic [1:0] KIND_REJECTED = 2'd1;
    localparam logic [1:0] KIND_ELEMENT  = 2'd2;
    localparam logic [1:0] KIND_EMPTY    = 2'd3;

    // controller to datapath commands
    typedef struct packed {
        logic load;         // capture the accepted word
        logic dir_desc;     // dump runs in descending order
        logic emit_reject;  // send a rejected-full result
        logic emit_empty;   // send a list-empty result
        logic ins_compare;  // compare every entry against the new value
        logic ins_write;    // shift the upper entries and write the new value
        logic dump_step;    // rotate the store one place and maybe send an element
    } ctl_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic full;
        logic empty;
        logic dump_last;    // rotation step counter at its final step
    } dp_status_t;

endpackage

@@ hdl/sil_ctrl.sv @@
// controller state machine sequencing inserts and dumps
module sil_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [1:0]          operation,
    input  sil_pkg::dp_status_t status,
    output sil_pkg::ctl_cmd_t   cmd,
    output logic                busy
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPARE,
        ST_SHIFT,
        ST_DUMP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (operation) inside
                        sil_pkg::OP_INSERT:
                        begin
                            cmd.load = 1'b1;
                            if (status.full)
                                cmd.emit_reject = 1'b1;
                            else
                                state_next = ST_COMPARE;
                        end
                        sil_pkg::OP_DUMP_ASC, sil_pkg::OP_DUMP_DESC:
                        begin
                            cmd.load     = 1'b1;
                            cmd.dir_desc = (operation == sil_pkg::OP_DUMP_DESC);
                            if (status.empty)
                                cmd.emit_empty = 1'b1;
                            else
                                state_next = ST_DUMP;
                        end
                        default:
                        begin
                            // unused code: dropped without a result
                        end
                    endcase
                end
            end
            ST_COMPARE:
            begin
                cmd.ins_compare = 1'b1;
                state_next      = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                cmd.ins_write = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_DUMP:
            begin
                cmd.dump_step = 1'b1;
                if (status.dump_last)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered busy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= (state_next != ST_IDLE);
        end
    end

    assign busy = busy_reg;

endmodule

@@ hdl/sil_datapath.sv @@
// sorted store, parallel compare, rotation stepper and result registers
module sil_datapath
#(
    parameter int CAPACITY = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  sil_pkg::ctl_cmd_t   cmd,
    input  logic signed [31:0]  value,
    output sil_pkg::dp_status_t status,
    output logic                result_valid,
    output logic [1:0]          kind,
    output logic signed [31:0]  item_value,
    output logic [3:0]          position,
    output logic [4:0]          entries_held,
    output logic                last
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int PW = (IW > 4) ? IW : 4;
    localparam int HW = (CW > 5) ? CW : 5;

    logic signed [31:0] store_reg [CAPACITY];
    logic signed [31:0] store_next [CAPACITY];
    logic [CW-1:0]      count_reg;
    logic [CAPACITY-1:0] lt_reg;
    logic signed [31:0] value_reg;
    logic               dir_reg;
    logic [IW-1:0]      step_reg;

    logic               strobe_reg;
    logic [1:0]         kind_reg;
    logic signed [31:0] item_value_reg;
    logic [3:0]         position_reg;
    logic [4:0]         held_reg;
    logic               last_reg;

    logic [IW-1:0]      ins_pos;
    logic [CW-1:0]      count_inc;
    logic               dump_emit;
    logic [IW-1:0]      dump_idx;
    logic               dump_is_last;
    logic signed [31:0] dump_value;
    logic [PW-1:0]      ins_pos_ext;
    logic [PW-1:0]      dump_idx_ext;
    logic [HW-1:0]      count_ext;
    logic [HW-1:0]      count_inc_ext;

    assign status.full      = (count_reg == CW'(CAPACITY));
    assign status.empty     = (count_reg == '0);
    assign status.dump_last = (step_reg == IW'(CAPACITY - 1));

    // insert position: top of the thermometer of entries below the new value
    always_comb
    begin
        ins_pos = '0;
        for (int k = 0; k < CAPACITY - 1; k++)
        begin
            if (lt_reg[k] && !lt_reg[k + 1])
                ins_pos = ins_pos | IW'(k + 1);
        end
    end

    assign count_inc = count_reg + CW'(1);

    // dump window and element index for the current rotation step
    always_comb
    begin
        if (dir_reg)
        begin
            dump_emit    = (CW'(step_reg) >= (CW'(CAPACITY) - count_reg));
            dump_idx     = IW'(CAPACITY - 1) - step_reg;
            dump_is_last = (step_reg == IW'(CAPACITY - 1));
            dump_value   = store_reg[CAPACITY - 1];
        end
        else
        begin
            dump_emit    = (CW'(step_reg) < count_reg);
            dump_idx     = step_reg;
            dump_is_last = ((CW'(step_reg) + CW'(1)) == count_reg);
            dump_value   = store_reg[0];
        end
    end

    assign ins_pos_ext   = PW'(ins_pos);
    assign dump_idx_ext  = PW'(dump_idx);
    assign count_ext     = HW'(count_reg);
    assign count_inc_ext = HW'(count_inc);

    // next store contents: insert shift or ring rotation
    always_comb
    begin
        for (int k = 0; k < CAPACITY; k++)
        begin
            store_next[k] = store_reg[k];
            if (cmd.ins_write)
            begin
                if (lt_reg[k])
                    store_next[k] = store_reg[k];
                else if (k == 0)
                    store_next[k] = value_reg;
                else if (lt_reg[(k + CAPACITY - 1) % CAPACITY])
                    store_next[k] = value_reg;
                else
                    store_next[k] = store_reg[(k + CAPACITY - 1) % CAPACITY];
            end
            else if (cmd.dump_step)
            begin
                if (dir_reg)
                    store_next[k] = store_reg[(k + CAPACITY - 1) % CAPACITY];
                else
                    store_next[k] = store_reg[(k + 1) % CAPACITY];
            end
        end
    end

    // store, compare vector and captured word
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < CAPACITY; k++)
            store_reg[k] <= store_next[k];
        if (cmd.ins_compare)
        begin
            for (int k = 0; k < CAPACITY; k++)
                lt_reg[k] <= (CW'(k) < count_reg) && (store_reg[k] < value_reg);
        end
        if (cmd.load)
        begin
            value_reg <= value;
            dir_reg   <= cmd.dir_desc;
        end
    end

    // fill count and rotation step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            step_reg  <= '0;
        end
        else
        begin
            if (cmd.ins_write)
                count_reg <= count_inc;
            if (cmd.load)
                step_reg <= '0;
            else if (cmd.dump_step)
                step_reg <= step_reg + IW'(1);
        end
    end

    // result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe_reg <= 1'b0;
        else
            strobe_reg <= cmd.emit_reject || cmd.emit_empty || cmd.ins_write
                          || (cmd.dump_step && dump_emit);
    end

    // result word
    always_ff @(posedge clk)
    begin
        if (cmd.emit_reject)
        begin
            kind_reg       <= sil_pkg::KIND_REJECTED;
            item_value_reg <= value;
            position_reg   <= 4'd0;
            held_reg       <= count_ext[4:0];
            last_reg       <= 1'b1;
        end
        else if (cmd.emit_empty)
        begin
            kind_reg       <= sil_pkg::KIND_EMPTY;
            item_value_reg <= 32'sd0;
            position_reg   <= 4'd0;
            held_reg       <= 5'd0;
            last_reg       <= 1'b1;
        end
        else if (cmd.ins_write)
        begin
            kind_reg       <= sil_pkg::KIND_INSERTED;
            item_value_reg <= value_reg;
            position_reg   <= ins_pos_ext[3:0];
            held_reg       <= count_inc_ext[4:0];
            last_reg       <= 1'b1;
        end
        else if (cmd.dump_step && dump_emit)
        begin
            kind_reg       <= sil_pkg::KIND_ELEMENT;
            item_value_reg <= dump_value;
            position_reg   <= dump_idx_ext[3:0];
            held_reg       <= count_ext[4:0];
            last_reg       <= dump_is_last;
        end
    end

    assign result_valid = strobe_reg;
    assign kind         = kind_reg;
    assign item_value   = item_value_reg;
    assign position     = position_reg;
    assign entries_held = held_reg;
    assign last         = last_reg;

endmodule

@@ hdl/sorted_insertion_list_core.sv @@
// Sorted insertion list: keeps up to CAPACITY signed 32-bit values in ascending order.
// A word is taken when start is high and busy is low. An insert passes a compare state,
// which checks every entry against the new value in parallel, and a shift state, which
// shifts the upper entries up and writes the value; its result shows in the cycle after
// that. A rejected insert or a dump of an empty list answers in the next cycle and
// leaves busy low. A dump walks the store as a ring of registers, one place per cycle,
// through one full turn (so the store ends where it started); it sends one element per
// cycle, all in consecutive cycles, the last one marked. The unused
// operation code is dropped. Every result is on the ports for one cycle with result_valid
// high and cannot be held off, so the receiver must take each one as it comes.
module sorted_insertion_list_core
#(
    parameter int CAPACITY = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         operation,
    input  logic signed [31:0] value,
    output logic               result_valid,
    output logic [1:0]         kind,
    output logic signed [31:0] item_value,
    output logic [3:0]         position,
    output logic [4:0]         entries_held,
    output logic               last
);

    sil_pkg::ctl_cmd_t   cmd;
    sil_pkg::dp_status_t status;

    // sequencing
    sil_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy)
    );

    // storage and results
    sil_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .value        (value),
        .status       (status),
        .result_valid (result_valid),
        .kind         (kind),
        .item_value   (item_value),
        .position     (position),
        .entries_held (entries_held),
        .last         (last)
    );

endmodule

@@ hdl/sil_checker.sv @@
// port-level checker for the sorted insertion list, bound to the top level
`include "sorted_insertion_list_core_macros.svh"

module sil_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic [1:0]         operation,
    input logic signed [31:0] value,
    input logic               result_valid,
    input logic [1:0]         kind,
    input logic signed [31:0] item_value,
    input logic [3:0]         position,
    input logic [4:0]         entries_held,
    input logic               last
);

    // single-result answers always close their word
    `SIL_ASSERT_IMP(a_single_last, result_valid && (kind != sil_pkg::KIND_ELEMENT), last, "insert or empty result without last")

    // an empty-list word carries zero payload
    `SIL_ASSERT_IMP(a_empty_word, result_valid && (kind == sil_pkg::KIND_EMPTY), (item_value == 32'sd0) && (position == 4'd0) && (entries_held == 5'd0), "empty result with nonzero fields")

    // dump elements come back to back until the last one
    `SIL_ASSERT_NXT(a_dump_burst, result_valid && !last, result_valid && (kind == sil_pkg::KIND_ELEMENT), "gap inside a dump burst")

    // a result that is not last belongs to a dump still in progress
    `SIL_ASSERT_IMP(a_mid_busy, result_valid && !last, busy, "mid-dump result while idle")

    // an accepted insert either starts work or answers at once
    `SIL_ASSERT_NXT(a_insert_reacts, start && !busy && (operation == sil_pkg::OP_INSERT) && (value == value), busy || (result_valid && (kind == sil_pkg::KIND_REJECTED)), "insert neither started nor rejected")

endmodule

bind sorted_insertion_list_core sil_checker u_sil_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .value        (value),
    .result_valid (result_valid),
    .kind         (kind),
    .item_value   (item_value),
    .position     (position),
    .entries_held (entries_held),
    .last         (last)
);
